/* sv/tmps_pkg.sv */
// ----------------------------------------------------------------------------
// tmps_pkg: shared types and constants for the triangle path sum core
// Field widths, sum limits and the per-element class flags.
// ----------------------------------------------------------------------------
package tmps_pkg;

	localparam int VALUE_W = 32;
	localparam int SUM_W   = 38;
	localparam int CFG_W   = 7;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// class of one element, set by the front from its row and column
	typedef struct packed {
		logic first_row;
		logic first_col;
		logic last_col;
		logic last_row;
	} flags_t;

endpackage

/* sv/tmps_ram.sv */
// ----------------------------------------------------------------------------
// tmps_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module tmps_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/tmps_front.sv */
// ----------------------------------------------------------------------------
// tmps_front: element tracker
// Hold the row count, track row and column of the next element and classify
// each accepted element for the back end.
// ----------------------------------------------------------------------------
module tmps_front #(
	parameter int MAX_ROWS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [tmps_pkg::CFG_W-1:0]        cfg_wr_data,
	input  logic                              accept,
	output logic [$clog2(MAX_ROWS)-1:0]       slot,
	output tmps_pkg::flags_t                  flags
);

	localparam int CW = $clog2(MAX_ROWS + 1);
	localparam int XW = (CW > tmps_pkg::CFG_W) ? CW : tmps_pkg::CFG_W;

	logic [tmps_pkg::CFG_W-1:0] row_count_q;
	logic [CW-1:0]              row_q;
	logic [CW-1:0]              col_q;
	logic [CW-1:0]              eff_rows;
	logic [XW-1:0]              rc_wide;

	always_comb begin
		rc_wide = XW'(row_count_q);
		if (row_count_q == '0) begin
			eff_rows = CW'(1);
		end else if (rc_wide > XW'(MAX_ROWS)) begin
			eff_rows = CW'(MAX_ROWS);
		end else begin
			eff_rows = rc_wide[CW-1:0];
		end
	end

	assign flags.first_row = (row_q == CW'(1));
	assign flags.first_col = (col_q == CW'(1));
	assign flags.last_col  = (col_q >= row_q);
	assign flags.last_row  = (row_q >= eff_rows);
	assign slot            = $clog2(MAX_ROWS)'(col_q - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= tmps_pkg::CFG_W'(1);
			row_q       <= CW'(1);
			col_q       <= CW'(1);
		end else begin
			if (cfg_wr_en) begin
				row_count_q <= cfg_wr_data;
			end
			if (accept) begin
				if (flags.last_col) begin
					// restart after the last row, else open the next row
					row_q <= flags.last_row ? CW'(1) : row_q + CW'(1);
					col_q <= CW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

endmodule

/* sv/tmps_fifo.sv */
// ----------------------------------------------------------------------------
// tmps_fifo: small word queue
// Decouple the front tracker from the back accumulator.
// ----------------------------------------------------------------------------
module tmps_fifo #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             full,
	output logic             not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [NW-1:0]    count_q;

	assign full      = (count_q == NW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + NW'(1);
				2'b01:   count_q <= count_q - NW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* sv/tmps_back.sv */
// ----------------------------------------------------------------------------
// tmps_back: path sum accumulator
// Read the parent sum, add the element, write back in place, track the best
// sum of the last row and hold the result word.
// ----------------------------------------------------------------------------
module tmps_back #(
	parameter int MAX_ROWS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	input  logic signed [tmps_pkg::VALUE_W-1:0] q_value,
	input  logic [$clog2(MAX_ROWS)-1:0]         q_slot,
	input  tmps_pkg::flags_t                    q_flags,
	output logic                                q_pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [tmps_pkg::SUM_W-1:0]   max_sum
);

	localparam int SW = $clog2(MAX_ROWS);
	localparam int SUM_W = tmps_pkg::SUM_W;
	localparam int VALUE_W = tmps_pkg::VALUE_W;

	logic                        valid_s1;
	logic signed [VALUE_W-1:0]   value_s1;
	logic [SW-1:0]               slot_s1;
	tmps_pkg::flags_t            flags_s1;
	logic                        fwd_s1;
	logic signed [SUM_W-1:0]     fwd_sum_s1;
	logic signed [SUM_W-1:0]     rdata;
	logic signed [SUM_W-1:0]     held_left_q;
	logic signed [SUM_W-1:0]     best_q;
	logic signed [SUM_W-1:0]     old;
	logic signed [SUM_W-1:0]     base;
	logic signed [SUM_W:0]       sum_wide;
	logic signed [SUM_W-1:0]     sum;
	logic signed [SUM_W-1:0]     best_upd;
	logic                        emit;
	logic                        advance;
	logic                        wr_en;

	assign emit    = valid_s1 && flags_s1.last_col && flags_s1.last_row;
	assign advance = !(emit && out_valid && !out_ready);
	assign q_pop   = advance && q_valid;
	assign wr_en   = advance && valid_s1;

	tmps_ram #(
		.WIDTH(SUM_W),
		.DEPTH(MAX_ROWS)
	) u_row_sums (
		.clk  (clk),
		.we   (wr_en),
		.waddr(slot_s1),
		.wdata(sum),
		.re   (advance),
		.raddr(q_slot),
		.rdata(rdata)
	);

	// take the sum being written on the read edge when the slots match
	assign old = fwd_s1 ? fwd_sum_s1 : rdata;

	always_comb begin
		priority if (flags_s1.first_row) begin
			base = '0;
		end else if (flags_s1.first_col) begin
			base = old;
		end else if (flags_s1.last_col) begin
			base = held_left_q;
		end else begin
			base = (held_left_q > old) ? held_left_q : old;
		end
		sum_wide = {base[SUM_W-1], base} +
			{{(SUM_W + 1 - VALUE_W){value_s1[VALUE_W-1]}}, value_s1};
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum = sum_wide[SUM_W] ? tmps_pkg::SUM_MIN : tmps_pkg::SUM_MAX;
		end else begin
			sum = sum_wide[SUM_W-1:0];
		end
		if (flags_s1.last_row && (flags_s1.first_col || sum > best_q)) begin
			best_upd = sum;
		end else begin
			best_upd = best_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			value_s1   <= q_value;
			slot_s1    <= q_slot;
			flags_s1   <= q_flags;
			fwd_s1     <= wr_en && (slot_s1 == q_slot);
			fwd_sum_s1 <= sum;
		end
		if (wr_en && emit) begin
			max_sum <= best_upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			held_left_q <= '0;
			best_q      <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1 <= q_valid;
			end
			if (wr_en) begin
				held_left_q <= emit ? '0 : old;
				best_q      <= emit ? '0 : best_upd;
			end
			if (wr_en && emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

/* sv/triangle_max_path_sum_core.sv */
// ----------------------------------------------------------------------------
// triangle_max_path_sum_core: streaming triangle maximum path sum
// Elements arrive in row-major order; the core keeps a row of best top-down
// sums and gives the largest full path sum after the last element.
// ----------------------------------------------------------------------------
//
//  port group   dir  handshake              word
//  -----------  ---  ---------------------  ------------------------------
//  input        in   in_valid / in_ready    value, signed 32 bits
//  result       out  out_valid / out_ready  max_sum, signed 38 bits
//  config       in   cfg_wr_en              row_count, 7 bits, reset 1
//
//  One element per cycle sustained unless a result word is stalled. A result
//  word is registered when the last element of a triangle has passed the queue
//  and stage s1. The rate is set by the single read-modify-write of the row
//  sum RAM. A result word not yet taken stalls the accumulator only; the front
//  keeps taking words until the four-entry queue fills. Reset is asynchronous.
//
module triangle_max_path_sum_core #(
	parameter int MAX_ROWS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [tmps_pkg::VALUE_W-1:0] value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [tmps_pkg::SUM_W-1:0]   max_sum,
	input  logic                                cfg_wr_en,
	input  logic [tmps_pkg::CFG_W-1:0]          row_count
);

	localparam int SW = $clog2(MAX_ROWS);
	localparam int FW = $bits(tmps_pkg::flags_t);
	localparam int EW = tmps_pkg::VALUE_W + SW + FW;

	logic                       accept;
	logic                       q_full;
	logic                       q_valid;
	logic                       q_pop;
	logic [SW-1:0]              f_slot;
	tmps_pkg::flags_t           f_flags;
	logic [EW-1:0]              q_head;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;

	// classify each word as it is taken
	tmps_front #(
		.MAX_ROWS(MAX_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(row_count),
		.accept     (accept),
		.slot       (f_slot),
		.flags      (f_flags)
	);

	// hold classified words between front and back
	tmps_fifo #(
		.WIDTH(EW),
		.DEPTH(4)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_data({value, f_slot, f_flags}),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.not_empty(q_valid)
	);

	// accumulate path sums and deliver the result word
	tmps_back #(
		.MAX_ROWS(MAX_ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_value  (q_head[EW-1 -: tmps_pkg::VALUE_W]),
		.q_slot   (q_head[FW +: SW]),
		.q_flags  (q_head[FW-1:0]),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.max_sum  (max_sum)
	);

endmodule

/* sv/tmps_checker.sv */
// ----------------------------------------------------------------------------
// tmps_checker: port-level checks for the triangle path sum core
// Result handshake rules and result-versus-input bookkeeping.
// ----------------------------------------------------------------------------
module tmps_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [tmps_pkg::SUM_W-1:0]        max_sum
);

	logic        seen_q;
	logic [31:0] in_cnt_q;
	logic [31:0] out_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 1'b0;
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				seen_q   <= 1'b1;
				in_cnt_q <= in_cnt_q + 32'd1;
			end
			if (out_valid && out_ready) begin
				out_cnt_q <= out_cnt_q + 32'd1;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped before taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(max_sum))
		else $error("result word changed while stalled");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seen_q)
		else $error("result word with no input taken");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= in_cnt_q)
		else $error("more result words than input words");

endmodule

bind triangle_max_path_sum_core tmps_checker u_tmps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.max_sum  (max_sum)
);

/* sim/triangle_max_path_sum_core_test.sv */
// ----------------------------------------------------------------------------
// triangle_max_path_sum_core_test: self-checking bench for the path sum core
// Streams number triangles of many sizes into the core with random gaps on
// both handshakes, predicts each maximum path sum and checks every result.
// ----------------------------------------------------------------------------

// Tracks the triangle being streamed and the maximum path sums it owes.
class triangle_sum_tracker #(int MAX_ROWS = 64);

	logic signed [tmps_pkg::SUM_W-1:0] best_row [MAX_ROWS];
	logic signed [tmps_pkg::SUM_W-1:0] held_left;
	logic signed [tmps_pkg::SUM_W-1:0] best_sum;
	int unsigned                       row_idx;
	int unsigned                       col_idx;
	logic [tmps_pkg::CFG_W-1:0]        rows_cfg;
	logic signed [tmps_pkg::SUM_W-1:0] pending_max_sums [$];
	int                                fail_count;

	function void reset_state();
		foreach (best_row[i]) best_row[i] = '0;
		held_left       = '0;
		best_sum        = '0;
		row_idx         = 1;
		col_idx         = 1;
		rows_cfg        = 1;
		fail_count      = 0;
		pending_max_sums.delete();
	endfunction

	function void set_rows(logic [tmps_pkg::CFG_W-1:0] rows);
		rows_cfg = rows;
	endfunction

	// zero acts as one, anything past the buffer depth acts as the depth
	function int unsigned rows_in_use();
		if (rows_cfg < 1) return 1;
		if (rows_cfg > MAX_ROWS) return MAX_ROWS;
		return rows_cfg;
	endfunction

	function int unsigned elements_to_close();
		int unsigned rows;
		int unsigned n;
		rows = rows_in_use();
		n = row_idx - col_idx + 1;
		for (int unsigned k = row_idx + 1; k <= rows; k++) n += k;
		return n;
	endfunction

	function int expected_count();
		return pending_max_sums.size();
	endfunction

	function logic signed [tmps_pkg::SUM_W-1:0] clamp_sum(longint s);
		if (s > longint'(tmps_pkg::SUM_MAX)) return tmps_pkg::SUM_MAX;
		if (s < longint'(tmps_pkg::SUM_MIN)) return tmps_pkg::SUM_MIN;
		return s[tmps_pkg::SUM_W-1:0];
	endfunction

	// Advance the triangle by one accepted element.
	function void take_element(logic signed [tmps_pkg::VALUE_W-1:0] v);
		int unsigned                       slot;
		bit                                last_row;
		logic signed [tmps_pkg::SUM_W-1:0] upper;
		logic signed [tmps_pkg::SUM_W-1:0] parent;
		logic signed [tmps_pkg::SUM_W-1:0] s;
		last_row = (row_idx >= rows_in_use());
		slot = col_idx - 1;
		if (slot >= MAX_ROWS) slot = MAX_ROWS - 1;
		upper = best_row[slot];
		if (row_idx <= 1) begin
			s = clamp_sum(longint'(v));
		end else begin
			// only the parent that exists counts at a row edge
			if (col_idx <= 1) parent = upper;
			else if (col_idx >= row_idx) parent = held_left;
			else parent = (held_left > upper) ? held_left : upper;
			s = clamp_sum(longint'(parent) + longint'(v));
		end
		best_row[slot] = s;
		held_left = upper;
		if (last_row && (col_idx <= 1 || s > best_sum)) best_sum = s;
		if (col_idx >= row_idx) begin
			if (last_row) begin
				pending_max_sums.push_back(best_sum);
				row_idx   = 1;
				held_left = '0;
				best_sum  = '0;
			end else begin
				row_idx++;
			end
			col_idx = 1;
		end else begin
			col_idx++;
		end
	endfunction

	function void check_max_sum(logic signed [tmps_pkg::SUM_W-1:0] actual);
		logic signed [tmps_pkg::SUM_W-1:0] want;
		if (pending_max_sums.size() == 0) begin
			$display("%0t: max_sum %0d arrived with none expected", $time, actual);
			fail_count++;
		end else begin
			want = pending_max_sums.pop_front();
			if (actual !== want) begin
				$display("%0t: max_sum expected %0d, actual %0d", $time, want, actual);
				fail_count++;
			end
		end
	endfunction

endclass

module triangle_max_path_sum_core_test;

	localparam int TRI_ROWS          = 64;
	localparam int SETTLE_CYCLES     = 12;
	localparam int CYCLE_LIMIT       = 200000;
	localparam int RANDOM_ELEMENTS   = 750;
	// triangles above this many elements are run in full only once
	localparam int SMALL_TRI_ELEMENTS = 136;

	localparam logic signed [tmps_pkg::VALUE_W-1:0] VALUE_MAX =
		{1'b0, {(tmps_pkg::VALUE_W-1){1'b1}}};
	localparam logic signed [tmps_pkg::VALUE_W-1:0] VALUE_MIN =
		{1'b1, {(tmps_pkg::VALUE_W-1){1'b0}}};

	typedef enum logic {
		MIX_PLAIN,
		MIX_PEAK
	} value_mix_t;

	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                in_valid  = 1'b0;
	logic                                in_ready;
	logic signed [tmps_pkg::VALUE_W-1:0] value     = '0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic signed [tmps_pkg::SUM_W-1:0]   max_sum;
	logic                                cfg_wr_en = 1'b0;
	logic [tmps_pkg::CFG_W-1:0]          cfg_rows  = '0;

	int                        cycle_count = 0;
	logic                      calm;
	value_mix_t                value_mix = MIX_PLAIN;

	triangle_sum_tracker #(TRI_ROWS) sb;

	triangle_max_path_sum_core #(
		.MAX_ROWS(TRI_ROWS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.max_sum  (max_sum),
		.cfg_wr_en(cfg_wr_en),
		.row_count(cfg_rows)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Periodically drop all idling on both sides for a long window.
	assign calm = (cycle_count % 2400) >= 1600;

	// Stall the result side in about a quarter of the cycles.
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 23);
	end

	// Check every result word taken at this edge against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_max_sum(max_sum);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("FAIL triangle_max_path_sum_core");
		$finish;
	end

	function automatic logic signed [tmps_pkg::VALUE_W-1:0] pick_value();
		int unsigned roll;
		int          near_zero;
		roll = $urandom_range(99);
		near_zero = $urandom_range(200);
		if (value_mix == MIX_PEAK && roll < 95) return VALUE_MAX;
		if (roll < 40) return $urandom;
		if (roll < 70) return near_zero - 100;
		if (roll < 80) return VALUE_MAX - $urandom_range(3);
		if (roll < 90) return VALUE_MIN + $urandom_range(3);
		return $urandom_range(1) ? '0 : '1;
	endfunction

	// Mostly small triangles, now and then an out-of-range or deep one.
	function automatic logic [tmps_pkg::CFG_W-1:0] pick_rows();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 6) return '0;
		if (roll < 9) return $urandom_range(1) ? 7'd64 : 7'd127;
		if (roll < 14) return 7'($urandom_range(16, 9));
		return 7'($urandom_range(8, 1));
	endfunction

	// Offer one element word, with random idle cycles ahead of it, and hold
	// it until taken.
	task automatic send_value(input logic signed [tmps_pkg::VALUE_W-1:0] v);
		while (!calm && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		sb.take_element(v);
	endtask

	task automatic send_values(input int unsigned n);
		for (int unsigned i = 0; i < n; i++) send_value(pick_value());
	endtask

	// Wait until the core owes nothing and has drained any words still inside.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_count() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_rows(input logic [tmps_pkg::CFG_W-1:0] rows);
		cfg_wr_en <= 1'b1;
		cfg_rows  <= rows;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_rows(rows);
	endtask

	initial begin
		int unsigned remaining;
		int unsigned n;
		int unsigned plain_sent;
		int unsigned round;
		bit          big_done;

		sb = new;
		sb.reset_state();
		plain_sent = 0;
		round      = 0;
		big_done   = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A row count of zero acts as a single row.
		set_rows(7'd0);
		send_value(VALUE_MIN);

		// Single-element triangles back to back: the largest value, zero and minus one.
		settle();
		set_rows(7'd1);
		send_value(VALUE_MAX);
		send_value('0);
		send_value(-1);

		// Two rows: both edge paths, the right one wins.
		settle();
		set_rows(7'd2);
		send_value(5);
		send_value(-3);
		send_value(7);

		// Three rows: extremes on the edges and an interior pick of parents.
		settle();
		set_rows(7'd3);
		send_value('0);
		send_value(VALUE_MIN);
		send_value(VALUE_MAX);
		send_value(VALUE_MAX);
		send_value(-5);
		send_value(VALUE_MIN);

		// Lower the row count below the current row mid-triangle: that row
		// becomes the last one.
		settle();
		set_rows(7'd4);
		send_value(10);
		send_value(-20);
		send_value(30);
		settle();
		set_rows(7'd2);
		send_values(sb.elements_to_close());

		// Raise the row count mid-triangle.
		settle();
		set_rows(7'd2);
		send_value(4);
		send_value(8);
		settle();
		set_rows(7'd3);
		send_values(sb.elements_to_close());

		// Random triangles: mostly whole ones, some cut short by a new row count.
		while (plain_sent < RANDOM_ELEMENTS) begin
			if (round == 3) begin
				settle();
				set_rows(7'd24);
			end else if (round == 6) begin
				settle();
				set_rows(7'd127);
			end else if ($urandom_range(1) == 1) begin
				settle();
				set_rows(pick_rows());
			end
			remaining = sb.elements_to_close();
			if (remaining > SMALL_TRI_ELEMENTS) begin
				if (!big_done) begin
					// one deep triangle, heavy on the largest element
					big_done  = 1'b1;
					value_mix = MIX_PEAK;
					send_values(remaining);
					plain_sent += remaining;
					value_mix = MIX_PLAIN;
				end else begin
					n = $urandom_range(40, 1);
					send_values(n);
					plain_sent += n;
					settle();
					set_rows(7'($urandom_range(8, 1)));
				end
			end else if (remaining > 1 && $urandom_range(99) < 15) begin
				n = $urandom_range(remaining - 1, 1);
				send_values(n);
				plain_sent += n;
				settle();
				set_rows(pick_rows());
			end else begin
				send_values(remaining);
				plain_sent += remaining;
			end
			round++;
		end

		settle();
		if (sb.fail_count == 0) begin
			$display("PASS triangle_max_path_sum_core");
		end else begin
			$display("FAIL triangle_max_path_sum_core");
		end
		$finish;
	end

endmodule

/* files.f */
sv/tmps_pkg.sv
sv/tmps_ram.sv
sv/tmps_front.sv
sv/tmps_fifo.sv
sv/tmps_back.sv
sv/triangle_max_path_sum_core.sv
sv/tmps_checker.sv
sim/triangle_max_path_sum_core_test.sv
